>>> src/rar_pkg.sv
package rar_pkg;

  // default datapath format, signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // register map, index of each register
  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_PLANE_AXIS   = 3'd0;
  localparam logic [2:0] REG_PLANE_OFFSET = 3'd1;
  localparam logic [2:0] REG_A_LOW        = 3'd2;
  localparam logic [2:0] REG_A_HIGH       = 3'd3;
  localparam logic [2:0] REG_B_LOW        = 3'd4;
  localparam logic [2:0] REG_B_HIGH       = 3'd5;
  localparam logic [2:0] REG_MATERIAL_ID  = 3'd6;

  // plane axis codes
  localparam logic [1:0] AXIS_XY     = 2'd0;
  localparam logic [1:0] AXIS_XZ     = 2'd1;
  localparam logic [1:0] AXIS_YZ     = 2'd2;
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  // per-stage control: stage holds an item, item still a candidate hit
  typedef struct packed {
    logic valid;
    logic live;
  } rar_ctl_t;

endpackage

>>> src/ray_axis_aligned_rect_intersect.sv
// Ray against one axis-aligned rectangle, signed fixed point.
//
// The rectangle (plane axis, plane offset, edge ranges, material) is set
// through the APB port; the user must change registers only while no ray is
// in flight, which the block does not enforce. Rays enter on the input
// channel (in_valid / in_stall), one per cycle while in_stall is low. Results
// leave on the output channel (out_valid / out_stall), one per ray, in order.
//
// The pipeline has DATA_WIDTH + 2*FRAC_BITS + 10 register stages (74 with the
// default Q16.16): two setup stages, a restoring divider for t with one
// quotient bit per stage, five stages for signed t, range check, products,
// hit point and bound checks, a divider for u and v with one bit per stage,
// and the output register. It takes one ray per cycle unless stalled.
//
// When the receiver stalls with a result waiting in the output register, the
// whole pipeline holds and in_stall is raised; nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values: an XY
// plane at zero spanning 0..1 in both coordinates, material 0.
module ray_axis_aligned_rect_intersect #(
  parameter int DATA_WIDTH = rar_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rar_pkg::FRAC_BITS_DEF,
  localparam int PDW       = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB  = (DATA_WIDTH > 32) ? 3 : 2,
  localparam int AW        = ADDR_LSB + $clog2(rar_pkg::NUM_REGS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AW-1:0]                paddr,
  input  logic [PDW-1:0]               pwdata,
  output logic [PDW-1:0]               prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] origin_x,
  input  logic signed [DATA_WIDTH-1:0] origin_y,
  input  logic signed [DATA_WIDTH-1:0] origin_z,
  input  logic signed [DATA_WIDTH-1:0] dir_x,
  input  logic signed [DATA_WIDTH-1:0] dir_y,
  input  logic signed [DATA_WIDTH-1:0] dir_z,
  input  logic signed [DATA_WIDTH-1:0] t_lower,
  input  logic signed [DATA_WIDTH-1:0] t_upper,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit_flag,
  output logic signed [DATA_WIDTH-1:0] t_value,
  output logic [FRAC_BITS:0]           u_coord,
  output logic [FRAC_BITS:0]           v_coord,
  output logic signed [DATA_WIDTH-1:0] point_x,
  output logic signed [DATA_WIDTH-1:0] point_y,
  output logic signed [DATA_WIDTH-1:0] point_z,
  output logic [1:0]                   normal_axis,
  output logic [7:0]                   hit_material
);
  import rar_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = DW + 1 + F;
  localparam int TW  = QW + 1;
  localparam int PW  = 2 * DW + 1;
  localparam int SW1 = 8 * DW + 1;
  localparam int SW2 = 4 * DW + 2;
  localparam logic [F:0] UV_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [PW-1:0] SAT_MAX = PW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

  logic adv;

  // configuration registers
  logic [1:0]           plane_axis;
  logic signed [DW-1:0] plane_offset;
  logic signed [DW-1:0] a_low;
  logic signed [DW-1:0] a_high;
  logic signed [DW-1:0] b_low;
  logic signed [DW-1:0] b_high;
  logic [7:0]           material_id;

  rar_cfg #(
    .DW(DW), .F(F), .PDW(PDW), .ADDR_LSB(ADDR_LSB), .AW(AW)
  ) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .plane_axis, .plane_offset, .a_low, .a_high, .b_low, .b_high, .material_id
  );

  // pipeline moves unless a result waits and the receiver stalls
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  function automatic logic signed [DW-1:0] sat_data(input logic signed [PW-1:0] v);
    if (v > SAT_MAX) return SAT_MAX[DW-1:0];
    if (v < SAT_MIN) return SAT_MIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  // normal component select
  logic signed [DW-1:0] sel_o;
  logic signed [DW-1:0] sel_d;
  logic signed [DW:0]   in_diff;

  always_comb begin
    unique case (plane_axis)
      AXIS_XY: begin sel_o = origin_z; sel_d = dir_z; end
      AXIS_XZ: begin sel_o = origin_y; sel_d = dir_y; end
      default: begin sel_o = origin_x; sel_d = dir_x; end
    endcase
  end

  assign in_diff = (DW+1)'(plane_offset) - (DW+1)'(sel_o);

  // stage a: input register, offset minus origin along the normal
  rar_ctl_t             a_ctl;
  logic signed [DW-1:0] a_ox, a_oy, a_oz, a_dx, a_dy, a_dz, a_tlo, a_thi, a_dn;
  logic signed [DW:0]   a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (adv) begin
      a_ctl.valid <= in_valid;
      a_ctl.live  <= (plane_axis != AXIS_UNUSED) && (sel_d != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ox   <= origin_x;
      a_oy   <= origin_y;
      a_oz   <= origin_z;
      a_dx   <= dir_x;
      a_dy   <= dir_y;
      a_dz   <= dir_z;
      a_tlo  <= t_lower;
      a_thi  <= t_upper;
      a_dn   <= sel_d;
      a_diff <= in_diff;
    end
  end

  // stage b: magnitudes and quotient sign
  rar_ctl_t           b_ctl;
  logic [DW:0]        b_num;
  logic [DW-1:0]      b_den;
  logic [SW1-1:0]     b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (adv) begin
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_num  <= a_diff[DW] ? (DW+1)'(-a_diff) : (DW+1)'(a_diff);
      b_den  <= a_dn[DW-1] ? DW'(-a_dn) : DW'(a_dn);
      b_side <= {a_ox, a_oy, a_oz, a_dx, a_dy, a_dz, a_tlo, a_thi,
                 a_diff[DW] ^ a_dn[DW-1]};
    end
  end

  // t divider
  rar_ctl_t        q_ctl;
  logic [QW-1:0]   q_quo;
  logic [SW1-1:0]  q_side;
  logic signed [DW-1:0] q_ox, q_oy, q_oz, q_dx, q_dy, q_dz, q_tlo, q_thi;
  logic            q_neg;

  rar_tdiv #(.DW(DW), .F(F), .SIDE_W(SW1)) u_tdiv (
    .clk, .rst, .adv,
    .in_ctl(b_ctl), .in_num(b_num), .in_den(b_den), .in_side(b_side),
    .out_ctl(q_ctl), .out_quo(q_quo), .out_side(q_side)
  );

  assign {q_ox, q_oy, q_oz, q_dx, q_dy, q_dz, q_tlo, q_thi, q_neg} = q_side;

  // stage c: signed t
  rar_ctl_t             c_ctl;
  logic signed [TW-1:0] c_t;
  logic signed [DW-1:0] c_ox, c_oy, c_oz, c_dx, c_dy, c_dz, c_tlo, c_thi;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else if (adv) begin
      c_ctl <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_t   <= q_neg ? -{1'b0, q_quo} : {1'b0, q_quo};
      c_ox  <= q_ox;
      c_oy  <= q_oy;
      c_oz  <= q_oz;
      c_dx  <= q_dx;
      c_dy  <= q_dy;
      c_dz  <= q_dz;
      c_tlo <= q_tlo;
      c_thi <= q_thi;
    end
  end

  // stage d: interval check
  rar_ctl_t             d_ctl;
  logic signed [DW-1:0] d_t, d_ox, d_oy, d_oz, d_dx, d_dy, d_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else if (adv) begin
      d_ctl.valid <= c_ctl.valid;
      d_ctl.live  <= c_ctl.live && (c_t >= TW'(c_tlo)) && (c_t <= TW'(c_thi));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_t  <= c_t[DW-1:0];
      d_ox <= c_ox;
      d_oy <= c_oy;
      d_oz <= c_oz;
      d_dx <= c_dx;
      d_dy <= c_dy;
      d_dz <= c_dz;
    end
  end

  // stage e: t times each direction component
  rar_ctl_t               e_ctl;
  logic signed [DW-1:0]   e_t, e_ox, e_oy, e_oz;
  logic signed [2*DW-1:0] e_px, e_py, e_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
    end else if (adv) begin
      e_ctl <= d_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_px <= d_t * d_dx;
      e_py <= d_t * d_dy;
      e_pz <= d_t * d_dz;
      e_t  <= d_t;
      e_ox <= d_ox;
      e_oy <= d_oy;
      e_oz <= d_oz;
    end
  end

  // stage f: hit point, origin plus floored product
  rar_ctl_t             f_ctl;
  logic signed [DW-1:0] f_t;
  logic signed [PW-1:0] f_x, f_y, f_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else if (adv) begin
      f_ctl <= e_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_x <= PW'(e_ox) + PW'(e_px >>> F);
      f_y <= PW'(e_oy) + PW'(e_py >>> F);
      f_z <= PW'(e_oz) + PW'(e_pz >>> F);
      f_t <= e_t;
    end
  end

  // in-plane coordinates and spans
  logic signed [PW-1:0] sel_a, sel_b;
  logic signed [PW-1:0] off_a, off_b;
  logic signed [DW:0]   span_a, span_b;
  logic                 in_rect;

  always_comb begin
    unique case (plane_axis)
      AXIS_XY: begin sel_a = f_x; sel_b = f_y; end
      AXIS_XZ: begin sel_a = f_x; sel_b = f_z; end
      default: begin sel_a = f_y; sel_b = f_z; end
    endcase
  end

  assign off_a   = sel_a - PW'(a_low);
  assign off_b   = sel_b - PW'(b_low);
  assign span_a  = (DW+1)'(a_high) - (DW+1)'(a_low);
  assign span_b  = (DW+1)'(b_high) - (DW+1)'(b_low);
  assign in_rect = (sel_a >= PW'(a_low)) && (sel_a <= PW'(a_high)) &&
                   (sel_b >= PW'(b_low)) && (sel_b <= PW'(b_high));

  // stage g: bound checks, saturation, u/v numerators
  rar_ctl_t           g_ctl;
  logic [1:0][DW-1:0] g_num;
  logic [1:0][DW-1:0] g_den;
  logic [SW2-1:0]     g_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_ctl <= '0;
    end else if (adv) begin
      g_ctl.valid <= f_ctl.valid;
      g_ctl.live  <= f_ctl.live && in_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_num[0] <= off_a[DW-1:0];
      g_num[1] <= off_b[DW-1:0];
      g_den[0] <= span_a[DW-1:0];
      g_den[1] <= span_b[DW-1:0];
      g_side   <= {f_t, sat_data(f_x), sat_data(f_y), sat_data(f_z),
                   span_a == '0, span_b == '0};
    end
  end

  // u and v divider
  rar_ctl_t             r_ctl;
  logic [1:0][F:0]      r_quo;
  logic [SW2-1:0]       r_side;
  logic signed [DW-1:0] r_t, r_x, r_y, r_z;
  logic                 r_zu, r_zv;

  rar_uvdiv #(.DW(DW), .F(F), .SIDE_W(SW2)) u_uvdiv (
    .clk, .rst, .adv,
    .in_ctl(g_ctl), .in_num(g_num), .in_den(g_den), .in_side(g_side),
    .out_ctl(r_ctl), .out_quo(r_quo), .out_side(r_side)
  );

  assign {r_t, r_x, r_y, r_z, r_zu, r_zv} = r_side;

  // output register, all fields zero on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_flag <= r_ctl.live;
      if (r_ctl.live) begin
        t_value      <= r_t;
        u_coord      <= r_zu ? '0 : r_quo[0];
        v_coord      <= r_zv ? '0 : r_quo[1];
        point_x      <= r_x;
        point_y      <= r_y;
        point_z      <= r_z;
        normal_axis  <= plane_axis;
        hit_material <= material_id;
      end else begin
        t_value      <= '0;
        u_coord      <= '0;
        v_coord      <= '0;
        point_x      <= '0;
        point_y      <= '0;
        point_z      <= '0;
        normal_axis  <= '0;
        hit_material <= '0;
      end
    end
  end

  // checks
  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_flag |-> (u_coord <= UV_ONE) && (v_coord <= UV_ONE))
    else $error("u or v beyond one on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_flag |-> (t_value == '0) && (point_x == '0) &&
                               (normal_axis == '0) && (hit_material == '0))
    else $error("miss result carries nonzero fields");

  a_hit_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_flag |-> (normal_axis != AXIS_UNUSED))
    else $error("hit reported for unused plane axis");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> src/rar_cfg.sv
module rar_cfg #(
  parameter int DW       = 32,
  parameter int F        = 16,
  parameter int PDW      = 32,
  parameter int ADDR_LSB = 2,
  parameter int AW       = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AW-1:0]         paddr,
  input  logic [PDW-1:0]        pwdata,
  output logic [PDW-1:0]        prdata,
  output logic                  pready,
  output logic [1:0]            plane_axis,
  output logic signed [DW-1:0]  plane_offset,
  output logic signed [DW-1:0]  a_low,
  output logic signed [DW-1:0]  a_high,
  output logic signed [DW-1:0]  b_low,
  output logic signed [DW-1:0]  b_high,
  output logic [7:0]            material_id
);
  import rar_pkg::*;

  localparam int IW = $clog2(NUM_REGS);

  logic [IW-1:0] idx;
  logic          wr;

  assign idx    = paddr[ADDR_LSB +: IW];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis   <= AXIS_XY;
      plane_offset <= '0;
      a_low        <= '0;
      a_high       <= DW'(64'd1 << F);
      b_low        <= '0;
      b_high       <= DW'(64'd1 << F);
      material_id  <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_PLANE_AXIS:   plane_axis   <= pwdata[1:0];
        REG_PLANE_OFFSET: plane_offset <= pwdata[DW-1:0];
        REG_A_LOW:        a_low        <= pwdata[DW-1:0];
        REG_A_HIGH:       a_high       <= pwdata[DW-1:0];
        REG_B_LOW:        b_low        <= pwdata[DW-1:0];
        REG_B_HIGH:       b_high       <= pwdata[DW-1:0];
        REG_MATERIAL_ID:  material_id  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PLANE_AXIS:   prdata = PDW'(plane_axis);
      REG_PLANE_OFFSET: prdata = PDW'(plane_offset);
      REG_A_LOW:        prdata = PDW'(a_low);
      REG_A_HIGH:       prdata = PDW'(a_high);
      REG_B_LOW:        prdata = PDW'(b_low);
      REG_B_HIGH:       prdata = PDW'(b_high);
      REG_MATERIAL_ID:  prdata = PDW'(material_id);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> src/rar_tdiv.sv
module rar_tdiv #(
  parameter int DW     = 32,
  parameter int F      = 16,
  parameter int SIDE_W = 1,
  localparam int QW    = DW + 1 + F
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  rar_pkg::rar_ctl_t  in_ctl,
  input  logic [DW:0]        in_num,
  input  logic [DW-1:0]      in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output rar_pkg::rar_ctl_t  out_ctl,
  output logic [QW-1:0]      out_quo,
  output logic [SIDE_W-1:0]  out_side
);
  import rar_pkg::*;

  // one quotient bit per stage, dividend and quotient share a shift register
  rar_ctl_t            ctl  [0:QW];
  logic [QW-1:0]       dq   [0:QW];
  logic [DW-1:0]       rem  [0:QW];
  logic [DW-1:0]       den  [0:QW];
  logic [SIDE_W-1:0]   side [0:QW];

  assign ctl[0]  = in_ctl;
  assign dq[0]   = {in_num, {F{1'b0}}};
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;

    assign trial = {rem[k], dq[k][QW-1]};
    assign diff  = trial - {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else if (adv) begin
        ctl[k+1] <= ctl[k];
      end
    end

    // restoring step
    always_ff @(posedge clk) begin
      if (adv) begin
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
        if (!diff[DW]) begin
          rem[k+1] <= diff[DW-1:0];
          dq[k+1]  <= {dq[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[DW-1:0];
          dq[k+1]  <= {dq[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_ctl  = ctl[QW];
  assign out_quo  = dq[QW];
  assign out_side = side[QW];

endmodule

>>> src/rar_uvdiv.sv
module rar_uvdiv #(
  parameter int DW     = 32,
  parameter int F      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  rar_pkg::rar_ctl_t    in_ctl,
  input  logic [1:0][DW-1:0]   in_num,
  input  logic [1:0][DW-1:0]   in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output rar_pkg::rar_ctl_t    out_ctl,
  output logic [1:0][F:0]      out_quo,
  output logic [SIDE_W-1:0]    out_side
);
  import rar_pkg::*;

  localparam int RW = DW + F;
  localparam int NS = F + 1;

  // two lanes (u and v), quotient bits from the top down, one per stage
  rar_ctl_t           ctl  [0:NS];
  logic [SIDE_W-1:0]  side [0:NS];
  logic [RW-1:0]      rem  [0:NS][0:1];
  logic [DW-1:0]      den  [0:NS][0:1];
  logic [F:0]         quo  [0:NS][0:1];

  assign ctl[0]  = in_ctl;
  assign side[0] = in_side;

  for (genvar l = 0; l < 2; l++) begin : g_in
    assign rem[0][l] = {in_num[l], {F{1'b0}}};
    assign den[0][l] = in_den[l];
    assign quo[0][l] = '0;
    assign out_quo[l] = quo[NS][l];
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = F - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else if (adv) begin
        ctl[s+1] <= ctl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[s+1] <= side[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW:0] diff;

      assign diff = {1'b0, rem[s][l]} - ({1'b0, RW'(den[s][l])} << K);

      // compare and subtract against the shifted span
      always_ff @(posedge clk) begin
        if (adv) begin
          den[s+1][l] <= den[s][l];
          quo[s+1][l] <= quo[s][l] | ((F+1)'(!diff[RW]) << K);
          rem[s+1][l] <= diff[RW] ? rem[s][l] : diff[RW-1:0];
        end
      end
    end
  end

  assign out_ctl  = ctl[NS];
  assign out_side = side[NS];

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rar_pkg::*;

  localparam int DW       = 32;
  localparam int FB       = 16;
  localparam int AW       = 5;
  localparam int LATENCY  = DW + 2 * FB + 10;
  localparam longint ONE  = 64'sd65536;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t;
    logic [16:0]        u, v;
    logic signed [31:0] px, py, pz;
    logic [1:0]         axis;
    logic [7:0]         mat;
  } hit_rec_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper;
  logic hit_flag;
  logic signed [31:0] t_value, point_x, point_y, point_z;
  logic [16:0] u_coord, v_coord;
  logic [1:0] normal_axis;
  logic [7:0] hit_material;

  ray_axis_aligned_rect_intersect uut (.*);

  // shadow copy of the rectangle registers
  logic [1:0] axis_q;
  longint     offset_q, alo_q, ahi_q, blo_q, bhi_q;
  logic [7:0] mat_q;

  hit_rec_t pending_hits[$];
  int errors, rays_sent, results_seen, hits_seen;
  bit quiet, hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still pending", pending_hits.size());
    $display("testbench failed");
    $finish;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [16:0] to_unit(longint c, longint lo, longint hi);
    longint span;
    span = hi - lo;
    if (span <= 0) return '0;
    return 17'(((c - lo) * ONE) / span);
  endfunction

  // expected result of one ray against the current rectangle
  function automatic hit_rec_t trace_rect(ray_t r);
    hit_rec_t h;
    longint org[3], dir[3], pt[3], tt;
    int n, ia, ib;
    h = '0;
    org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
    dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
    case (axis_q)
      AXIS_XY: begin n = 2; ia = 0; ib = 1; end
      AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
      AXIS_YZ: begin n = 0; ia = 1; ib = 2; end
      default: return h;
    endcase
    if (dir[n] == 0) return h;
    tt = ((offset_q - org[n]) * ONE) / dir[n];
    if (tt < longint'(r.tlo) || tt > longint'(r.thi)) return h;
    for (int i = 0; i < 3; i++) pt[i] = org[i] + ((tt * dir[i]) >>> FB);
    if (pt[ia] < alo_q || pt[ia] > ahi_q || pt[ib] < blo_q || pt[ib] > bhi_q) return h;
    h.hit  = 1'b1;
    h.t    = 32'(tt);
    h.u    = to_unit(pt[ia], alo_q, ahi_q);
    h.v    = to_unit(pt[ib], blo_q, bhi_q);
    h.px   = 32'(sat32(pt[0]));
    h.py   = 32'(sat32(pt[1]));
    h.pz   = 32'(sat32(pt[2]));
    h.axis = axis_q;
    h.mat  = mat_q;
    return h;
  endfunction

  // output stall: random bursts, long hold-off on request, none when quiet
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      hit_rec_t e, a;
      a = '{hit_flag, t_value, u_coord, v_coord, point_x, point_y, point_z,
            normal_axis, hit_material};
      results_seen++;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, a);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (e.hit) hits_seen++;
        if (e.hit != a.hit) begin
          $display("%0t: hit_flag exp %0d act %0d", $time, e.hit, a.hit); errors++;
        end
        if (e.t != a.t) begin
          $display("%0t: t_value exp %h act %h", $time, e.t, a.t); errors++;
        end
        if (e.u != a.u) begin
          $display("%0t: u_coord exp %h act %h", $time, e.u, a.u); errors++;
        end
        if (e.v != a.v) begin
          $display("%0t: v_coord exp %h act %h", $time, e.v, a.v); errors++;
        end
        if (e.px != a.px) begin
          $display("%0t: point_x exp %h act %h", $time, e.px, a.px); errors++;
        end
        if (e.py != a.py) begin
          $display("%0t: point_y exp %h act %h", $time, e.py, a.py); errors++;
        end
        if (e.pz != a.pz) begin
          $display("%0t: point_z exp %h act %h", $time, e.pz, a.pz); errors++;
        end
        if (e.axis != a.axis) begin
          $display("%0t: normal_axis exp %0d act %0d", $time, e.axis, a.axis); errors++;
        end
        if (e.mat != a.mat) begin
          $display("%0t: hit_material exp %h act %h", $time, e.mat, a.mat); errors++;
        end
      end
    end
  end

  // one ray transfer; returns after the accepting edge, or after a random gap with in_valid low
  task automatic send_ray(ray_t r);
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper} <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hits.push_back(trace_rect(r));
    rays_sent++;
    // random input gap
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // apb register write, also updates the shadow copy
  task automatic set_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PLANE_AXIS:   axis_q = value[1:0];
      REG_PLANE_OFFSET: offset_q = longint'(signed'(value));
      REG_A_LOW:        alo_q = longint'(signed'(value));
      REG_A_HIGH:       ahi_q = longint'(signed'(value));
      REG_B_LOW:        blo_q = longint'(signed'(value));
      REG_B_HIGH:       bhi_q = longint'(signed'(value));
      REG_MATERIAL_ID:  mat_q = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_rect(logic [1:0] ax, longint off, longint alo, longint ahi,
                          longint blo, longint bhi, logic [7:0] mat);
    set_reg(REG_PLANE_AXIS, 32'(ax));
    set_reg(REG_PLANE_OFFSET, 32'(off));
    set_reg(REG_A_LOW, 32'(alo));
    set_reg(REG_A_HIGH, 32'(ahi));
    set_reg(REG_B_LOW, 32'(blo));
    set_reg(REG_B_HIGH, 32'(bhi));
    set_reg(REG_MATERIAL_ID, 32'(mat));
  endtask

  function automatic logic signed [31:0] rnd32();
    return signed'($urandom);
  endfunction

  function automatic longint rnd_range(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // ray aimed near the rectangle, or pure noise
  function automatic ray_t make_ray(bit aimed);
    ray_t r;
    longint org[3], dir[3];
    int n, ia, ib;
    r = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()};
    if (!aimed || axis_q == AXIS_UNUSED) return r;
    case (axis_q)
      AXIS_XY: begin n = 2; ia = 0; ib = 1; end
      AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
      default: begin n = 0; ia = 1; ib = 2; end
    endcase
    for (int i = 0; i < 3; i++) dir[i] = rnd_range(-4 * ONE, 4 * ONE);
    if (dir[n] > -ONE / 4 && dir[n] < ONE / 4) dir[n] = ($urandom_range(0, 1)) ? ONE : -ONE;
    if ($urandom_range(0, 15) == 0) dir[n] = 0;
    org[n] = offset_q - rnd_range(-8 * ONE, 8 * ONE);
    org[ia] = alo_q + rnd_range(-(ahi_q - alo_q) / 2, (ahi_q - alo_q) * 3 / 2);
    org[ib] = blo_q + rnd_range(-(bhi_q - blo_q) / 2, (bhi_q - blo_q) * 3 / 2);
    for (int i = 0; i < 3; i++)
      if (i != n && $urandom_range(0, 1)) dir[i] = rnd_range(-ONE / 8, ONE / 8);
    r.ox = 32'(org[0]); r.oy = 32'(org[1]); r.oz = 32'(org[2]);
    r.dx = 32'(dir[0]); r.dy = 32'(dir[1]); r.dz = 32'(dir[2]);
    case ($urandom_range(0, 3))
      0: begin
        r.tlo = 32'(rnd_range(-4 * ONE, 0));
        r.thi = 32'(rnd_range(0, 16 * ONE));
      end
      1: begin r.tlo = 0; r.thi = rnd32(); end
      default: begin r.tlo = 32'h8000_0000; r.thi = 32'h7fff_ffff; end
    endcase
    return r;
  endfunction

  function automatic ray_t mk(longint ox, oy, oz, dx, dy, dz, tlo, thi);
    return {32'(ox), 32'(oy), 32'(oz), 32'(dx), 32'(dy), 32'(dz), 32'(tlo), 32'(thi)};
  endfunction

  // directed rays against the reset rectangle and special cases
  task automatic test_directed();
    longint h;
    h = ONE / 2;
    send_ray(mk(h, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    send_ray(mk(h, h, -ONE, ONE, ONE, 0, 0, 10 * ONE));
    send_ray(mk(h, h, -ONE, 0, 0, ONE, 2 * ONE, ONE));
    send_ray(mk(0, 0, -ONE, 0, 0, ONE, 0, ONE));
    send_ray(mk(ONE, ONE, ONE, 0, 0, -ONE, ONE, ONE));
    send_ray(mk(ONE + 1, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    send_ray(mk(h, -1, -ONE, 0, 0, ONE, 0, 10 * ONE));
    send_ray(mk(h, h, -ONE, 0, 0, ONE, ONE + 1, 10 * ONE));
    send_ray(mk(h, h, 2 * ONE, h / 4, -h / 4, -ONE, 0, 10 * ONE));
    send_ray(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                -32'sh80000000, -32'sh80000000, -32'sh80000000,
                -32'sh80000000, 32'sh7fffffff));
    send_ray(mk(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                -32'sh80000000, 32'sh7fffffff));
    send_ray(mk(h, h, -32'sh80000000, 0, 0, 1, -32'sh80000000, 32'sh7fffffff));
    send_ray(mk(h, h, 32'sh7fffffff, 0, 0, -32'sh80000000, -32'sh80000000, 32'sh7fffffff));
    send_ray(mk(h, h, -ONE, 0, 0, 3, -32'sh80000000, 32'sh7fffffff));
    drain();
    // degenerate and inverted ranges, unused axis
    set_rect(AXIS_XY, 0, h, h, 0, ONE, 8'h5a);
    send_ray(mk(h, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    send_ray(mk(h + 1, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    drain();
    set_rect(AXIS_XY, 0, ONE, 0, 0, ONE, 8'h5a);
    send_ray(mk(h, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    drain();
    set_rect(AXIS_UNUSED, 0, 0, ONE, 0, ONE, 8'h5a);
    send_ray(mk(h, h, -ONE, 0, 0, ONE, 0, 10 * ONE));
    drain();
  endtask

  // YZ and XZ plane axes with the register extremes
  task automatic test_edge_config();
    set_rect(AXIS_YZ, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff,
             -32'sh80000000, 32'sh7fffffff, 8'hff);
    for (int i = 0; i < 40; i++) send_ray(make_ray(i % 2));
    send_ray(mk(0, 0, 0, ONE, 0, 0, -32'sh80000000, 32'sh7fffffff));
    drain();
    set_rect(AXIS_XZ, -32'sh80000000, -32'sh80000000, 32'sh7fffffff,
             -32'sh80000000, 32'sh7fffffff, 8'h00);
    for (int i = 0; i < 40; i++) send_ray(make_ray(i % 2));
    send_ray(mk(0, 0, 0, 0, -ONE, 0, -32'sh80000000, 32'sh7fffffff));
    drain();
  endtask

  task automatic random_rect();
    longint alo, blo;
    alo = rnd_range(-4 * ONE, 4 * ONE);
    blo = rnd_range(-4 * ONE, 4 * ONE);
    set_rect(2'($urandom_range(0, 2)), rnd_range(-4 * ONE, 4 * ONE),
             alo, alo + rnd_range(1, 8 * ONE), blo, blo + rnd_range(1, 8 * ONE),
             8'($urandom));
  endtask

  task automatic test_random_rects();
    for (int k = 0; k < 8; k++) begin
      random_rect();
      for (int i = 0; i < 80; i++) send_ray(make_ray($urandom_range(0, 4) != 0));
      drain();
    end
  endtask

  // receiver holds off while rays keep coming, filling the pipeline
  task automatic test_backpressure();
    random_rect();
    quiet = 1;
    hold_req = 1;
    for (int i = 0; i < 150; i++) send_ray(make_ray(1));
    drain();
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    random_rect();
    quiet = 1;
    for (int i = 0; i < 100; i++) send_ray(make_ray($urandom_range(0, 4) != 0));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper} = '0;
    axis_q = AXIS_XY; offset_q = 0; alo_q = 0; ahi_q = ONE; blo_q = 0; bhi_q = ONE;
    mat_q = 0;
    errors = 0; rays_sent = 0; results_seen = 0; hits_seen = 0;
    quiet = 0; hold_req = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_edge_config();
    test_random_rects();
    quiet = 0;
    test_backpressure();
    test_full_rate();
    $display("covered %0d rays over all plane axes and register extremes, %0d results, %0d hits",
             rays_sent, results_seen, hits_seen);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_hits.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
